// ===== hw/rtl/itrd_pkg.sv =====
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared constants and helpers for the integer to radix digit converter.
// ----------------------------------------------------------------------------
package itrd_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int DIV_CHUNK     = 8;
  localparam int DIGIT_W       = 6;
  localparam int CHAR_W        = 7;
  localparam int RADIX_W       = 6;
  localparam int APB_AW        = 3;
  localparam int APB_DW        = 32;

  localparam logic             RADIX_IDX     = 1'b0;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  localparam logic [CHAR_W-1:0]  CH_ZERO       = 7'd48;
  localparam logic [CHAR_W-1:0]  CH_ALPHA_BASE = 7'd55;
  localparam logic [CHAR_W-1:0]  CH_MINUS      = 7'd45;
  localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 6'd10;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d < DECIMAL_LIMIT) begin
      digit_char = dx + CH_ZERO;
    end else begin
      digit_char = dx + CH_ALPHA_BASE;
    end
  endfunction

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) begin
      clamp_radix = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      clamp_radix = RADIX_MAX;
    end else begin
      clamp_radix = r;
    end
  endfunction

endpackage

// ===== hw/rtl/integer_to_radix_digits.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Signed integer to ASCII text in a programmable base from 2 to 36.
// ----------------------------------------------------------------------------
// Each accepted value leaves as a string of beats, most significant digit
// first, '-' ahead of a negative magnitude, last set on the final beat. The
// radix register (byte address 0, reset 10) is clamped to 2..36 where it is
// used as the base. For each item the engine picks it up, finds each digit
// by one division by the base, eight dividend bits a cycle, then sends an
// optional sign beat and the digit beats, each digit beat with a digit memory
// read and an output register load. A two-entry input queue takes new values
// while the digit engine works.
module integer_to_radix_digits import itrd_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic [APB_AW-1:0]    paddr_i,
  input  logic [APB_DW-1:0]    pwdata_i,
  output logic [APB_DW-1:0]    prdata_o,
  output logic                 pready_o,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [WORD_BITS-1:0] value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CHAR_W-1:0]    character_o,
  output logic                 last_o
);

  logic [RADIX_W-1:0]   radix_q;
  logic                 radix_sel;
  logic                 item_valid;
  logic                 item_pop;
  logic                 item_neg;
  logic [WORD_BITS-1:0] item_mag;

  assign pready_o  = 1'b1;
  assign radix_sel = (paddr_i[APB_AW-1] == RADIX_IDX);
  assign prdata_o  = radix_sel ? APB_DW'(radix_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (psel_i && penable_i && pwrite_i && pready_o && radix_sel) begin
      radix_q <= pwdata_i[RADIX_W-1:0];
    end
  end

  itrd_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop),
    .item_neg_o   (item_neg),
    .item_mag_o   (item_mag)
  );

  itrd_back #(
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .base_i       (clamp_radix(radix_q)),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .item_neg_i   (item_neg),
    .item_mag_i   (item_mag),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .character_o  (character_o),
    .last_o       (last_o)
  );

endmodule

// ===== hw/rtl/itrd_front.sv =====
// ----------------------------------------------------------------------------
// itrd_front
// Input side: accepts a value, splits it into sign and magnitude and holds it
// in a two-entry queue for the digit engine.
// ----------------------------------------------------------------------------
module itrd_front import itrd_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [WORD_BITS-1:0] value_i,
  output logic                 item_valid_o,
  input  logic                 item_pop_i,
  output logic                 item_neg_o,
  output logic [WORD_BITS-1:0] item_mag_o
);

  logic                 neg_q [2];
  logic [WORD_BITS-1:0] mag_q [2];
  logic                 wr_ptr_q, wr_ptr_d;
  logic                 rd_ptr_q, rd_ptr_d;
  logic [1:0]           count_q, count_d;
  logic                 push;
  logic                 pop;
  logic                 neg;
  logic [WORD_BITS-1:0] mag;

  assign neg        = value_i[WORD_BITS-1];
  assign mag        = neg ? (~value_i + 1'b1) : value_i;
  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = item_pop_i && item_valid_o;

  assign item_valid_o = (count_q != 2'd0);
  assign item_neg_o   = neg_q[rd_ptr_q];
  assign item_mag_o   = mag_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      neg_q[wr_ptr_q] <= neg;
      mag_q[wr_ptr_q] <= mag;
    end
  end

endmodule

// ===== hw/rtl/itrd_back.sv =====
// ----------------------------------------------------------------------------
// itrd_back
// Digit engine: repeated division by the base, a chunk of dividend bits per
// cycle, digits kept in a small memory and sent out most significant first.
// ----------------------------------------------------------------------------
module itrd_back import itrd_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [RADIX_W-1:0]   base_i,
  input  logic                 item_valid_i,
  output logic                 item_pop_o,
  input  logic                 item_neg_i,
  input  logic [WORD_BITS-1:0] item_mag_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CHAR_W-1:0]    character_o,
  output logic                 last_o
);

  localparam int STEPS  = (WORD_BITS + DIV_CHUNK - 1) / DIV_CHUNK;
  localparam int DVD_W  = STEPS * DIV_CHUNK;
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int CNT_W  = $clog2(WORD_BITS + 1);
  localparam int AW     = $clog2(WORD_BITS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SIGN = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [DVD_W-1:0]   dvd_q, dvd_d;
  logic [DIGIT_W-1:0] rem_q, rem_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               neg_q, neg_d;
  logic               out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]  char_q, char_d;
  logic               last_q, last_d;

  logic [DVD_W-1:0]   dvd_next;
  logic [DIGIT_W-1:0] rem_next;
  logic               last_step;
  logic               slot_free;
  logic               mem_we;
  logic               mem_re;
  logic [CNT_W-1:0]   cnt_dec;
  logic [DIGIT_W-1:0] mem [WORD_BITS];
  logic [DIGIT_W-1:0] rd_data_q;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign last_step = (step_q == STEP_W'(STEPS - 1));
  assign cnt_dec   = cnt_q - 1'b1;
  assign mem_we    = (state_q == S_DIV) && last_step;
  assign mem_re    = (state_q == S_RD);

  always_comb begin
    logic [DIGIT_W:0]    t;
    logic [DIGIT_W-1:0]  r;
    logic [DIV_CHUNK-1:0] qb;
    r  = rem_q;
    qb = '0;
    for (int i = 0; i < DIV_CHUNK; i++) begin
      t = {r, dvd_q[DVD_W-1-i]};
      if (t >= {1'b0, base_i}) begin
        qb[DIV_CHUNK-1-i] = 1'b1;
        t = t - {1'b0, base_i};
      end
      r = t[DIGIT_W-1:0];
    end
    rem_next = r;
    dvd_next = (dvd_q << DIV_CHUNK) | DVD_W'(qb);
  end

  always_comb begin
    state_d     = state_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    out_valid_d = slot_free ? 1'b0 : out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    item_pop_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          dvd_d      = DVD_W'(item_mag_i);
          neg_d      = item_neg_i;
          rem_d      = '0;
          step_d     = '0;
          cnt_d      = '0;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        dvd_d  = dvd_next;
        rem_d  = rem_next;
        step_d = step_q + 1'b1;
        if (last_step) begin
          rem_d  = '0;
          step_d = '0;
          cnt_d  = cnt_q + 1'b1;
          if (dvd_next == '0) begin
            state_d = neg_q ? S_SIGN : S_RD;
          end
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          char_d      = CH_MINUS;
          last_d      = 1'b0;
          state_d     = S_RD;
        end
      end
      S_RD: begin
        state_d = S_WR;
      end
      S_WR: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          char_d      = digit_char(rd_data_q);
          last_d      = (cnt_q == CNT_W'(1));
          cnt_d       = cnt_dec;
          state_d     = (cnt_q == CNT_W'(1)) ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cnt_q[AW-1:0]] <= rem_next;
    end
    if (mem_re) begin
      rd_data_q <= mem[cnt_dec[AW-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

// ===== hw/rtl/itrd_checker.sv =====
// ----------------------------------------------------------------------------
// itrd_assertions
// Port-level checks for the integer to radix digit converter.
// ----------------------------------------------------------------------------
module itrd_assertions import itrd_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [CHAR_W-1:0]    character_o,
  input logic                 last_o
);

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (character_o == CH_MINUS) ||
                    (character_o >= 7'd48 && character_o <= 7'd57) ||
                    (character_o >= 7'd65 && character_o <= 7'd90))
    else $error("illegal character on output");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && character_o == CH_MINUS) |-> !last_o)
    else $error("sign beat marked last");

  a_minus_then_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && character_o == CH_MINUS) |=>
      !(out_valid_o && character_o == CH_MINUS))
    else $error("sign beat repeated");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(character_o) && $stable(last_o)))
    else $error("stalled output beat changed");

endmodule

bind integer_to_radix_digits itrd_assertions u_itrd_assertions (.*);
